### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/llqm_pkg.sv
package llqm_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W  = 2;
  localparam int DIN_W  = 32;
  localparam int SLOT_W = 4;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADSLOT = 2'd3;

  typedef struct packed {
    logic capture;
    logic step1;
    logic step2;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic relink;
  } sts_t;

endpackage

### rtl/llqm_in_if.sv
interface llqm_in_if;
  logic                        valid;
  logic                        ready;
  logic [llqm_pkg::CMD_W-1:0]  command;
  logic [llqm_pkg::DIN_W-1:0]  data_in;
  logic [llqm_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output command, output data_in, output slot, input ready);
  modport sink   (input valid, input command, input data_in, input slot, output ready);
endinterface

### rtl/llqm_out_if.sv
interface llqm_out_if;
  logic                        valid;
  logic                        ready;
  logic [llqm_pkg::ST_W-1:0]   status;
  logic [llqm_pkg::SLOT_W-1:0] slot_out;
  logic [llqm_pkg::DIN_W-1:0]  data_out;
  logic                        list_empty;

  modport source (output valid, output status, output slot_out, output data_out,
                  output list_empty, input ready);
  modport sink   (input valid, input status, input slot_out, input data_out,
                  input list_empty, output ready);
endinterface

### rtl/llqm_ctrl.sv
module llqm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  llqm_pkg::sts_t  sts,
  output llqm_pkg::ctl_t  ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LINK   = 2'd1;
  localparam logic [1:0] S_RELINK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       can_load;

  assign can_load  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_LINK;
        end
      end
      S_LINK: begin
        if (sts.relink) begin
          ctl.step1  = 1'b1;
          state_next = S_RELINK;
        end else if (can_load) begin
          ctl.step1  = 1'b1;
          ctl.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RELINK: begin
        if (can_load) begin
          ctl.step2  = 1'b1;
          ctl.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/llqm_dpath.sv
module llqm_dpath #(
  parameter int ENTRIES    = llqm_pkg::ENTRIES_DEF,
  parameter int DATA_WIDTH = llqm_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  llqm_pkg::ctl_t              ctl,
  output llqm_pkg::sts_t              sts,
  input  logic [llqm_pkg::CMD_W-1:0]  command,
  input  logic [llqm_pkg::DIN_W-1:0]  data_in,
  input  logic [llqm_pkg::SLOT_W-1:0] slot,
  output logic [llqm_pkg::ST_W-1:0]   status,
  output logic [llqm_pkg::SLOT_W-1:0] slot_out,
  output logic [llqm_pkg::DIN_W-1:0]  data_out,
  output logic                        list_empty
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = llqm_pkg::SLOT_W;
  localparam int DW = llqm_pkg::DIN_W;

  logic [DATA_WIDTH-1:0] payload_mem [ENTRIES];
  logic [IW-1:0]         next_mem    [ENTRIES];
  logic [IW-1:0]         prev_mem    [ENTRIES];

  logic [llqm_pkg::CMD_W-1:0] cmd_q;
  logic [DATA_WIDTH-1:0]      data_q;
  logic [SW-1:0]              slot_q;
  logic [IW-1:0]              rd_next;
  logic [IW-1:0]              rd_prev;
  logic [DATA_WIDTH-1:0]      rd_data;

  logic [IW-1:0]      head, head_next;
  logic [IW-1:0]      tail, tail_next;
  logic [CW-1:0]      count, count_next;
  logic [ENTRIES-1:0] alloc, alloc_next;

  logic [SW+IW-1:0]         slot_in_wide;
  logic [SW+IW-1:0]         slot_q_wide;
  logic [DW+DATA_WIDTH-1:0] din_wide;
  logic [IW-1:0]            raddr;
  logic [IW-1:0]            slot_idx;
  logic                     slot_ok;
  logic                     slot_valid;
  logic [IW-1:0]            tgt;
  logic                     is_head;
  logic                     is_tail;
  logic [ENTRIES-1:0]       low_free;
  logic [IW-1:0]            free_idx;

  logic                  do_unlink;
  logic                  do_free;
  logic                  nx_we, pv_we, pl_we;
  logic [IW-1:0]         nx_wa, nx_wd, pv_wa, pv_wd, pl_wa;
  logic [llqm_pkg::ST_W-1:0] res_status;
  logic [IW-1:0]         res_slot;
  logic                  res_data_sel;
  logic [IW+SW-1:0]      res_slot_wide;
  logic [DW+DATA_WIDTH-1:0] res_data_wide;
  logic                  upd;

  assign slot_in_wide = {{IW{1'b0}}, slot};
  assign slot_q_wide  = {{IW{1'b0}}, slot_q};
  assign din_wide     = {{DATA_WIDTH{1'b0}}, data_in};
  assign raddr        = (command == llqm_pkg::CMD_POP) ? tail : slot_in_wide[IW-1:0];
  assign slot_idx     = slot_q_wide[IW-1:0];
  assign slot_ok      = slot_q_wide < (SW+IW)'(ENTRIES);
  assign slot_valid   = slot_ok && alloc[slot_idx];
  assign tgt          = (cmd_q == llqm_pkg::CMD_POP) ? tail : slot_idx;
  assign is_head      = (tgt == head);
  assign is_tail      = (tgt == tail);
  assign sts.relink   = (cmd_q == llqm_pkg::CMD_MOVE) && slot_valid && !is_head;
  assign upd          = ctl.step1 || ctl.step2;

  // lowest clear bit of the allocation marks, one-hot
  assign low_free = ~alloc & (alloc + ENTRIES'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (low_free[i]) begin
        free_idx = free_idx | IW'(i);
      end
    end
  end

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    alloc_next   = alloc;
    do_unlink    = 1'b0;
    do_free      = 1'b0;
    nx_we        = 1'b0;
    nx_wa        = '0;
    nx_wd        = '0;
    pv_we        = 1'b0;
    pv_wa        = '0;
    pv_wd        = '0;
    pl_we        = 1'b0;
    pl_wa        = '0;
    res_status   = llqm_pkg::ST_OK;
    res_slot     = '0;
    res_data_sel = 1'b0;
    if (ctl.step2) begin
      // second half of move to front: link at head
      pv_we     = 1'b1;
      pv_wa     = head;
      pv_wd     = tgt;
      nx_we     = 1'b1;
      nx_wa     = tgt;
      nx_wd     = head;
      head_next = tgt;
    end else begin
      case (cmd_q)
        llqm_pkg::CMD_PUSH: begin
          if (count == CW'(ENTRIES)) begin
            res_status = llqm_pkg::ST_FULL;
          end else begin
            pl_we = 1'b1;
            pl_wa = free_idx;
            nx_we = 1'b1;
            nx_wa = free_idx;
            nx_wd = head;
            if (count != '0) begin
              pv_we = 1'b1;
              pv_wa = head;
              pv_wd = free_idx;
            end else begin
              tail_next = free_idx;
            end
            head_next            = free_idx;
            alloc_next[free_idx] = 1'b1;
            count_next           = count + CW'(1);
            res_slot             = free_idx;
          end
        end
        llqm_pkg::CMD_POP: begin
          if (count == '0) begin
            res_status = llqm_pkg::ST_EMPTY;
          end else begin
            do_unlink    = 1'b1;
            do_free      = 1'b1;
            res_data_sel = 1'b1;
          end
        end
        llqm_pkg::CMD_MOVE: begin
          if (!slot_valid) begin
            res_status = llqm_pkg::ST_BADSLOT;
          end else if (!is_head) begin
            do_unlink = 1'b1;
          end
        end
        llqm_pkg::CMD_DEL: begin
          if (!slot_valid) begin
            res_status = llqm_pkg::ST_BADSLOT;
          end else begin
            do_unlink = 1'b1;
            do_free   = 1'b1;
          end
        end
        default: res_status = llqm_pkg::ST_OK;
      endcase
      if (do_unlink) begin
        if (is_head) begin
          head_next = rd_next;
          if (is_tail) begin
            tail_next = '0;
          end
        end else begin
          nx_we = 1'b1;
          nx_wa = rd_prev;
          nx_wd = rd_next;
          if (!is_tail) begin
            pv_we = 1'b1;
            pv_wa = rd_next;
            pv_wd = rd_prev;
          end else begin
            tail_next = rd_prev;
          end
        end
      end
      if (do_free) begin
        alloc_next[tgt] = 1'b0;
        count_next      = count - CW'(1);
        if (count == CW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end
      end
    end
  end

  assign res_slot_wide = {{SW{1'b0}}, res_slot};
  assign res_data_wide = {{DW{1'b0}}, rd_data};

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= command;
      data_q  <= din_wide[DATA_WIDTH-1:0];
      slot_q  <= slot;
      rd_next <= next_mem[raddr];
      rd_prev <= prev_mem[raddr];
      rd_data <= payload_mem[raddr];
    end
    if (upd && nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (upd && pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (upd && pl_we) begin
      payload_mem[pl_wa] <= data_q;
    end
    if (ctl.load) begin
      status     <= res_status;
      slot_out   <= res_slot_wide[SW-1:0];
      data_out   <= res_data_sel ? res_data_wide[DW-1:0] : '0;
      list_empty <= (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      alloc <= '0;
    end else if (upd) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      alloc <= alloc_next;
    end
  end

endmodule

### rtl/linked_list_queue_move_to_front_unit.sv
// channel | dir | beat carries                          | handshake
// req     | in  | command, data_in, slot                | valid/ready
// rsp     | out | status, slot_out, data_out, list_empty | valid/ready
//
// Push, pop, delete, move of the head and refused commands: the result is registered in LINK once
// the result register is free; the unit then returns to idle before it takes the next beat.
// Move of a slot other than the head: the unlink is written in LINK, the link at head in RELINK,
// which registers the result; the relink needs a second write to the single-port link memories.
// A new beat is taken once the result is registered, even while it waits on rsp; the next
// result then holds until the waiting one is taken.
// Synchronous reset clears marks, head, tail and count; link and payload memories are not cleared.
module linked_list_queue_move_to_front_unit #(
  parameter int ENTRIES    = llqm_pkg::ENTRIES_DEF,
  parameter int DATA_WIDTH = llqm_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  llqm_in_if.sink    req,
  llqm_out_if.source rsp
);

  llqm_pkg::ctl_t ctl;
  llqm_pkg::sts_t sts;

  llqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  llqm_dpath #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .command    (req.command),
    .data_in    (req.data_in),
    .slot       (req.slot),
    .status     (rsp.status),
    .slot_out   (rsp.slot_out),
    .data_out   (rsp.data_out),
    .list_empty (rsp.list_empty)
  );

endmodule

### rtl/llqm_checker.sv
`include "assert_macros.svh"

module llqm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [llqm_pkg::ST_W-1:0]   status,
  input logic [llqm_pkg::SLOT_W-1:0] slot_out,
  input logic [llqm_pkg::DIN_W-1:0]  data_out,
  input logic                        list_empty
);

  // one command in flight at a time
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  `ASSERT_IMPLY(a_full_not_empty, clk, rst, rsp_valid && status == llqm_pkg::ST_FULL, !list_empty)
  `ASSERT_IMPLY(a_empty_flag, clk, rst, rsp_valid && status == llqm_pkg::ST_EMPTY, list_empty)
  `ASSERT_IMPLY(a_fail_no_payload, clk, rst, rsp_valid && status != llqm_pkg::ST_OK, slot_out == '0 && data_out == '0)
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(data_out) && $stable(slot_out))

endmodule

bind linked_list_queue_move_to_front_unit llqm_checker u_llqm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .slot_out   (rsp.slot_out),
  .data_out   (rsp.data_out),
  .list_empty (rsp.list_empty)
);

### tb/linked_list_queue_move_to_front_unit_tb.sv
module linked_list_queue_move_to_front_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS     = llqm_pkg::ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CMD_W       = llqm_pkg::CMD_W;
  localparam int DIN_W       = llqm_pkg::DIN_W;
  localparam int SLOT_W      = llqm_pkg::SLOT_W;
  localparam int ST_W        = llqm_pkg::ST_W;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_out;
    logic [DIN_W-1:0]  data_out;
    logic              list_empty;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  llqm_in_if  req();
  llqm_out_if rsp();

  linked_list_queue_move_to_front_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // mirror of the list
  logic [DIN_W-1:0]  lst_payload [N_SLOTS] = '{default: '0};
  logic [SLOT_W-1:0] lst_next    [N_SLOTS] = '{default: '0};
  logic [SLOT_W-1:0] lst_prev    [N_SLOTS] = '{default: '0};
  logic [N_SLOTS-1:0] lst_used  = '0;
  logic [SLOT_W-1:0]  lst_head  = '0;
  logic [SLOT_W-1:0]  lst_tail  = '0;
  logic [SLOT_W:0]    lst_count = '0;

  list_result_t pending_results[$];
  int error_count  = 0;
  int cycle_count  = 0;
  int stall_cycles = 0;
  bit no_idle      = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void unlink_entry(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] nx;
    logic [SLOT_W-1:0] pv;
    nx = lst_next[s];
    pv = lst_prev[s];
    if (s == lst_head) begin
      lst_head = nx;
      if (s == lst_tail) lst_tail = '0;
    end else begin
      lst_next[pv] = nx;
      if (s != lst_tail) lst_prev[nx] = pv;
      else lst_tail = pv;
    end
  endfunction

  function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                  logic [DIN_W-1:0] data,
                                                  logic [SLOT_W-1:0] s_in);
    list_result_t r;
    logic [SLOT_W-1:0] s;
    r = '0;
    r.status = llqm_pkg::ST_OK;
    s = s_in;
    case (cmd)
      llqm_pkg::CMD_PUSH: begin
        if (lst_count >= N_SLOTS) begin
          r.status = llqm_pkg::ST_FULL;
        end else begin
          for (int i = N_SLOTS - 1; i >= 0; i--)
            if (!lst_used[i]) s = SLOT_W'(i);
          lst_payload[s] = data;
          lst_used[s] = 1'b1;
          lst_prev[s] = s;
          lst_next[s] = lst_head;
          if (lst_count != 0) lst_prev[lst_head] = s;
          else lst_tail = s;
          lst_head = s;
          lst_count++;
          r.slot_out = s;
        end
      end
      llqm_pkg::CMD_POP: begin
        if (lst_count == 0) begin
          r.status = llqm_pkg::ST_EMPTY;
        end else begin
          s = lst_tail;
          r.data_out = lst_payload[s];
          unlink_entry(s);
          lst_used[s] = 1'b0;
          lst_count--;
        end
      end
      default: begin
        if (!lst_used[s]) begin
          r.status = llqm_pkg::ST_BADSLOT;
        end else if (cmd == llqm_pkg::CMD_MOVE) begin
          if (s != lst_head) begin
            unlink_entry(s);
            lst_prev[lst_head] = s;
            lst_next[s] = lst_head;
            lst_prev[s] = s;
            lst_head = s;
          end
        end else begin
          unlink_entry(s);
          lst_used[s] = 1'b0;
          lst_count--;
        end
      end
    endcase
    if (lst_count == 0) begin
      lst_head = '0;
      lst_tail = '0;
    end
    r.list_empty = (lst_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [DIN_W-1:0] got, logic [DIN_W-1:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, status", DIN_W'(rsp.status), '0);
      end else begin
        list_result_t want;
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", DIN_W'(rsp.status), DIN_W'(want.status));
        if (rsp.slot_out !== want.slot_out)
          report_mismatch("slot_out", DIN_W'(rsp.slot_out), DIN_W'(want.slot_out));
        if (rsp.data_out !== want.data_out)
          report_mismatch("data_out", rsp.data_out, want.data_out);
        if (rsp.list_empty !== want.list_empty)
          report_mismatch("list_empty", DIN_W'(rsp.list_empty), DIN_W'(want.list_empty));
      end
    end
  end

  // result side: long hold-off on request, else random stalls unless no_idle is set
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      rsp.ready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else begin
      rsp.ready <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // entered and left just after a rising edge; valid is left high on exit and dropped only for random idle cycles
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [DIN_W-1:0] data,
                           logic [SLOT_W-1:0] s);
    while (!no_idle && $urandom_range(99) < 13) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.data_in <= data;
    req.slot    <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(apply_list_cmd(cmd, data, s));
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DIN_W-1:0] random_data();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom_range(N_SLOTS - 1));
    if (lst_count != 0 && $urandom_range(99) < 85)
      while (!lst_used[s]) s = SLOT_W'($urandom_range(N_SLOTS - 1));
    return s;
  endfunction

  task automatic send_random_beat(int push_pct);
    logic [CMD_W-1:0] cmd;
    if ($urandom_range(99) < push_pct) begin
      cmd = llqm_pkg::CMD_PUSH;
    end else begin
      case ($urandom_range(2))
        0:       cmd = llqm_pkg::CMD_POP;
        1:       cmd = llqm_pkg::CMD_MOVE;
        default: cmd = llqm_pkg::CMD_DEL;
      endcase
    end
    send_beat(cmd, random_data(), pick_slot());
  endtask

  task automatic test_empty_list();
    send_beat(llqm_pkg::CMD_POP, '1, '1);
    send_beat(llqm_pkg::CMD_MOVE, '0, '0);
    send_beat(llqm_pkg::CMD_DEL, '0, '1);
  endtask

  task automatic test_fill_to_full();
    logic [DIN_W-1:0] patterns [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                      32'h5555_5555, 32'h0000_0001, 32'h8000_0000};
    for (int i = 0; i < N_SLOTS; i++)
      send_beat(llqm_pkg::CMD_PUSH, (i < 6) ? patterns[i] : DIN_W'($urandom), SLOT_W'(i));
    send_beat(llqm_pkg::CMD_PUSH, '1, '0);
  endtask

  task automatic test_ends_and_middle();
    send_beat(llqm_pkg::CMD_MOVE, '0, lst_head);
    send_beat(llqm_pkg::CMD_MOVE, '0, lst_tail);
    send_beat(llqm_pkg::CMD_MOVE, '0, SLOT_W'(7));
    send_beat(llqm_pkg::CMD_DEL, '0, lst_head);
    send_beat(llqm_pkg::CMD_DEL, '0, lst_tail);
    send_beat(llqm_pkg::CMD_DEL, '0, SLOT_W'(10));
    send_beat(llqm_pkg::CMD_POP, '0, '0);
  endtask

  task automatic test_random_mix();
    int bias [6] = '{15, 70, 30, 85, 50, 10};
    for (int i = 0; i < 1200; i++)
      send_random_beat(bias[(i / 100) % 6]);
  endtask

  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    for (int i = 0; i < 150; i++)
      send_random_beat(50);
    no_idle = 1'b0;
  endtask

  task automatic test_result_backpressure();
    stall_cycles = 300;
    for (int i = 0; i < 60; i++)
      send_random_beat(55);
    req.valid <= 1'b0;
    @(posedge clk);
    wait_results_done();
    for (int i = 0; i < 20; i++)
      send_random_beat(40);
  endtask

  initial begin
    req.valid   = 1'b0;
    req.command = llqm_pkg::CMD_PUSH;
    req.data_in = '0;
    req.slot    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_fill_to_full();
    test_ends_and_middle();
    test_random_mix();
    test_no_idle_stretch();
    test_result_backpressure();

    req.valid <= 1'b0;
    wait_results_done();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
